>>> hw/rtl/mfd_pkg.sv
// Shared types and constants of the motor feedback frame decoder.
`default_nettype none
package mfd_pkg;

	localparam int unsigned LIMIT_W = 24;
	localparam int unsigned VALUE_W = 25;

	localparam logic [22:0] POS_LIMIT_RST = 23'd819200;
	localparam logic [23:0] VEL_LIMIT_RST = 24'd1966080;
	localparam logic [22:0] TRQ_LIMIT_RST = 23'd655360;

	// Half a turn in Q16.16, rounded down.
	localparam logic signed [24:0] PI_Q16 = 25'sd205887;

	localparam logic signed [15:0] COUNT_MAX = 16'sh7FFF;
	localparam logic signed [15:0] COUNT_MIN = 16'sh8000;

	typedef enum logic [1:0] {
		CFG_POS_LIMIT = 2'd0,
		CFG_VEL_LIMIT = 2'd1,
		CFG_TRQ_LIMIT = 2'd2
	} mfd_cfg_idx_t;

	// Load strobes of the scaling stages, shared by all three lanes.
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
		logic ld_s5;
	} mfd_adv_t;

	// Fields that ride along the pipeline untouched.
	typedef struct packed {
		logic [3:0] fault_state;
		logic [7:0] mos_temperature;
		logic [7:0] rotor_temperature;
	} mfd_meta_t;

endpackage
`default_nettype wire

>>> hw/rtl/mfd_map.sv
// One scaling lane: maps a raw code linearly onto the range -limit..+limit.
`default_nettype none
module mfd_map (
	input  wire logic                           clk,
	input  wire mfd_pkg::mfd_adv_t              adv,
	input  wire logic                           wide,
	input  wire logic [15:0]                    code_s1,
	input  wire logic [mfd_pkg::LIMIT_W-1:0]    limit,
	output logic signed [mfd_pkg::VALUE_W-1:0]  value_s5
);

	localparam logic [17:0] DEN16  = 18'd65535;
	localparam logic [17:0] DEN12  = 18'd4095;
	localparam logic [40:0] HALF16 = 41'd32767;
	localparam logic [40:0] HALF12 = 41'd2047;

	logic [39:0]        prod;
	logic [40:0]        m_next;
	logic [40:0]        m_s2;
	logic [25:0]        t1;
	logic [25:0]        t2;
	logic [25:0]        t3;
	logic [25:0]        qa_next;
	logic [25:0]        qa_s3;
	logic [17:0]        m_lo_s3;
	logic [17:0]        qa_shift;
	logic [17:0]        r_next;
	logic [25:0]        qa_s4;
	logic [17:0]        r_s4;
	logic [17:0]        den1;
	logic [17:0]        den2;
	logic [17:0]        den3;
	logic [1:0]         corr;
	logic [25:0]        q;
	logic signed [26:0] val_w;

	// Rounded quotient is floor((2*code*limit + (den-1)/2) / den).
	assign prod   = 40'(code_s1) * 40'(limit);
	assign m_next = {prod, 1'b0} + (wide ? HALF16 : HALF12);

	// Division by 2^b-1 as a sum of shifted copies; it falls short by at most three.
	always_comb begin
		if (wide) begin
			t1 = {1'b0, m_s2[40:16]};
			t2 = {17'b0, m_s2[40:32]};
			t3 = 26'd0;
		end else begin
			t1 = m_s2[37:12];
			t2 = {12'b0, m_s2[37:24]};
			t3 = {24'b0, m_s2[37:36]};
		end
		qa_next = t1 + t2 + t3;
	end

	// The remainder is below 2^18, so only its low bits need computing.
	assign qa_shift = wide ? {qa_s3[1:0], 16'b0} : {qa_s3[5:0], 12'b0};
	assign r_next   = m_lo_s3 - qa_shift + qa_s3[17:0];

	always_comb begin
		den1  = wide ? DEN16 : DEN12;
		den2  = {den1[16:0], 1'b0};
		den3  = den2 + den1;
		corr  = 2'({1'b0, r_s4 >= den1} + {1'b0, r_s4 >= den2} + {1'b0, r_s4 >= den3});
		q     = qa_s4 + {24'b0, corr};
		val_w = $signed({1'b0, q}) - $signed({3'b0, limit});
	end

	always_ff @(posedge clk) begin
		if (adv.ld_s2) begin
			m_s2 <= m_next;
		end
		if (adv.ld_s3) begin
			qa_s3   <= qa_next;
			m_lo_s3 <= m_s2[17:0];
		end
		if (adv.ld_s4) begin
			qa_s4 <= qa_s3;
			r_s4  <= r_next;
		end
		if (adv.ld_s5) begin
			value_s5 <= val_w[mfd_pkg::VALUE_W-1:0];
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/mfd_turn.sv
// Turn counter: detects position wraps and keeps a saturating signed count.
`default_nettype none
module mfd_turn (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               ld,
	input  wire logic signed [23:0] pos,
	output logic signed [15:0]      wrap_q
);

	logic signed [23:0] prev_q;
	logic signed [24:0] diff;
	logic signed [15:0] wrap_next;

	always_comb begin
		diff      = $signed({pos[23], pos}) - $signed({prev_q[23], prev_q});
		wrap_next = wrap_q;
		if (diff > mfd_pkg::PI_Q16) begin
			if (wrap_q != mfd_pkg::COUNT_MIN) begin
				wrap_next = wrap_q - 16'sd1;
			end
		end else if (diff < -mfd_pkg::PI_Q16) begin
			if (wrap_q != mfd_pkg::COUNT_MAX) begin
				wrap_next = wrap_q + 16'sd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			wrap_q <= '0;
		end else if (ld) begin
			prev_q <= pos;
			wrap_q <= wrap_next;
		end
	end

`ifndef SYNTHESIS
	a_wrap_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!ld |=> $stable(wrap_q) && $stable(prev_q))
		else $error("turn count moved without a new frame");

	a_no_wrap_over_top: assert property (@(posedge clk) disable iff (!arst_n)
		(wrap_q == mfd_pkg::COUNT_MAX) |=> (wrap_q != mfd_pkg::COUNT_MIN))
		else $error("turn count overflowed instead of saturating");

	a_step_of_one: assert property (@(posedge clk) disable iff (!arst_n)
		ld |=> (wrap_q == $past(wrap_q)) || (wrap_q == $past(wrap_q) + 16'sd1)
			|| (wrap_q == $past(wrap_q) - 16'sd1))
		else $error("turn count changed by more than one");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/motor_feedback_frame_decoder_core.sv
// Top level of the motor feedback frame decoder: handshake, pipeline and config registers.
//
// Usage:
//   A frame beat is taken on in_valid/in_ready with the 64-bit frame, byte 0 in
//   bits 63..56. Each frame yields exactly one result beat on out_valid/out_ready
//   carrying the decoded fields, the turn count and the total angle.
//   The limits are written on cfg_valid/cfg_ready (always ready) with cfg_index
//   0 = position, 1 = velocity, 2 = torque limit; other indexes are ignored.
//   Write them only while no frame is in flight.
//   The datapath is a seven-stage pipeline: input register, multiply, quotient
//   estimate, remainder, correction, turn tracking, output register. One frame
//   is taken every cycle while the receiver keeps taking results.
//   When the receiver stalls, the result holds in the output register and
//   frames keep entering until every stage is occupied; then in_ready drops.
//   Reset empties the pipeline, loads the default limits and clears the stored
//   position and the turn count.
`default_nettype none
module motor_feedback_frame_decoder_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [63:0]        frame,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [3:0]              fault_state,
	output logic signed [23:0]      position,
	output logic signed [24:0]      velocity,
	output logic signed [23:0]      torque,
	output logic [7:0]              mos_temperature,
	output logic [7:0]              rotor_temperature,
	output logic signed [15:0]      turn_count,
	output logic signed [47:0]      multi_turn_angle,
	output logic                    alive,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [23:0]        cfg_data
);

	logic [22:0] pos_limit_q;
	logic [23:0] vel_limit_q;
	logic [22:0] trq_limit_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7;

	mfd_pkg::mfd_adv_t  adv;
	mfd_pkg::mfd_meta_t meta_s1, meta_s2, meta_s3, meta_s4, meta_s5, meta_s6, meta_s7;

	logic [15:0] pcode_s1;
	logic [15:0] vcode_s1;
	logic [15:0] tcode_s1;

	logic signed [24:0] pos_val_s5;
	logic signed [24:0] vel_val_s5;
	logic signed [24:0] trq_val_s5;

	logic signed [23:0] pos_s6;
	logic signed [24:0] vel_s6;
	logic signed [23:0] trq_s6;
	logic signed [15:0] wrap_q;

	logic signed [40:0] turn_prod;
	logic signed [47:0] total_next;

	logic signed [23:0] position_s7;
	logic signed [24:0] velocity_s7;
	logic signed [23:0] torque_s7;
	logic signed [15:0] turn_s7;
	logic signed [47:0] total_s7;
	logic               alive_s7;

	// A stage takes a new beat when it is empty or its content moves on.
	always_comb begin
		rdy_s7 = !v_s7 || out_ready;
		rdy_s6 = !v_s6 || rdy_s7;
		rdy_s5 = !v_s5 || rdy_s6;
		rdy_s4 = !v_s4 || rdy_s5;
		rdy_s3 = !v_s3 || rdy_s4;
		rdy_s2 = !v_s2 || rdy_s3;
		rdy_s1 = !v_s1 || rdy_s2;
		adv.ld_s2 = rdy_s2;
		adv.ld_s3 = rdy_s3;
		adv.ld_s4 = rdy_s4;
		adv.ld_s5 = rdy_s5;
	end

	assign in_ready  = rdy_s1;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
			if (rdy_s7) v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_limit_q <= mfd_pkg::POS_LIMIT_RST;
			vel_limit_q <= mfd_pkg::VEL_LIMIT_RST;
			trq_limit_q <= mfd_pkg::TRQ_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				mfd_pkg::CFG_POS_LIMIT: pos_limit_q <= cfg_data[22:0];
				mfd_pkg::CFG_VEL_LIMIT: vel_limit_q <= cfg_data;
				mfd_pkg::CFG_TRQ_LIMIT: trq_limit_q <= cfg_data[22:0];
				default: begin
				end
			endcase
		end
	end

	// Frame unpacking into the input register.
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			meta_s1.fault_state       <= frame[63:60];
			meta_s1.mos_temperature   <= frame[15:8];
			meta_s1.rotor_temperature <= frame[7:0];
			pcode_s1                  <= frame[55:40];
			vcode_s1                  <= {4'b0, frame[39:28]};
			tcode_s1                  <= {4'b0, frame[27:16]};
		end
		if (rdy_s2) meta_s2 <= meta_s1;
		if (rdy_s3) meta_s3 <= meta_s2;
		if (rdy_s4) meta_s4 <= meta_s3;
		if (rdy_s5) meta_s5 <= meta_s4;
		if (rdy_s6) begin
			meta_s6 <= meta_s5;
			pos_s6  <= pos_val_s5[23:0];
			vel_s6  <= vel_val_s5;
			trq_s6  <= trq_val_s5[23:0];
		end
		if (rdy_s7) begin
			meta_s7     <= meta_s6;
			position_s7 <= pos_s6;
			velocity_s7 <= vel_s6;
			torque_s7   <= trq_s6;
			turn_s7     <= wrap_q;
			total_s7    <= total_next;
			alive_s7    <= (meta_s6.fault_state != 4'd0);
		end
	end

	mfd_map u_map_pos (
		.clk      (clk),
		.adv      (adv),
		.wide     (1'b1),
		.code_s1  (pcode_s1),
		.limit    ({1'b0, pos_limit_q}),
		.value_s5 (pos_val_s5)
	);

	mfd_map u_map_vel (
		.clk      (clk),
		.adv      (adv),
		.wide     (1'b0),
		.code_s1  (vcode_s1),
		.limit    (vel_limit_q),
		.value_s5 (vel_val_s5)
	);

	mfd_map u_map_trq (
		.clk      (clk),
		.adv      (adv),
		.wide     (1'b0),
		.code_s1  (tcode_s1),
		.limit    ({1'b0, trq_limit_q}),
		.value_s5 (trq_val_s5)
	);

	// The count is updated as a frame enters stage six, so wrap_q belongs to it there.
	mfd_turn u_turn (
		.clk    (clk),
		.arst_n (arst_n),
		.ld     (rdy_s6 && v_s5),
		.pos    (pos_val_s5[23:0]),
		.wrap_q (wrap_q)
	);

	assign turn_prod  = 41'(wrap_q) * 41'($signed({1'b0, pos_limit_q, 1'b0}));
	assign total_next = 48'(turn_prod) + 48'(pos_s6);

	assign out_valid         = v_s7;
	assign fault_state       = meta_s7.fault_state;
	assign mos_temperature   = meta_s7.mos_temperature;
	assign rotor_temperature = meta_s7.rotor_temperature;
	assign position          = position_s7;
	assign velocity          = velocity_s7;
	assign torque            = torque_s7;
	assign turn_count        = turn_s7;
	assign multi_turn_angle  = total_s7;
	assign alive             = alive_s7;

`ifndef SYNTHESIS
	a_alive_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (alive == (fault_state != 4'd0)))
		else $error("alive flag disagrees with fault state");

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> in_ready)
		else $error("input refused with an empty input stage");

	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && v_s7 && !out_ready) |-> !in_ready)
		else $error("input taken while the pipeline is full and stalled");
`endif

endmodule
`default_nettype wire
